// ===== hw/rtl/dq_pkg.sv =====
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DQ_DEPTH      = 128;
    localparam int DQ_DATA_WIDTH = 32;

    // port widths fixed by the item format
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 8;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef logic [VALUE_W-1:0] value_t;

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// results: push, query and refused commands give their result in the cycle after the input transfer;
// a pop that leaves elements behind gives it after the store read and then the output register
// throughput: one item per cycle if out_ready; a pop leaving elements blocks input for its read (single read port)
// front and back elements are cached in registers, the circular store holds every element
// reset clears indices, count and output valid; store contents stay undefined, no clearing pass
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = DQ_DEPTH,
    parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CMD_W-1:0]           command,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  popped_value,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  front_value,
    output logic signed [VALUE_W-1:0]  back_value,
    output logic [OCC_W-1:0]           occupancy,
    output logic                       is_empty
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    typedef logic [DATA_WIDTH-1:0] elem_t;

    function automatic value_t to_port(elem_t d);
        value_t r;
        r = '0;
        for (int i = 0; i < VALUE_W && i < DATA_WIDTH; i++)
        begin
            r[i] = d[i];
        end
        return r;
    endfunction

    function automatic elem_t from_port(value_t v);
        elem_t r;
        r = '0;
        for (int i = 0; i < VALUE_W && i < DATA_WIDTH; i++)
        begin
            r[i] = v[i];
        end
        return r;
    endfunction

    function automatic logic [OCC_W-1:0] to_occ(logic [CW-1:0] c);
        logic [OCC_W-1:0] r;
        r = '0;
        for (int i = 0; i < OCC_W && i < CW; i++)
        begin
            r[i] = c[i];
        end
        return r;
    endfunction

    function automatic logic [IW-1:0] idx_inc(logic [IW-1:0] i);
        return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(logic [IW-1:0] i);
        return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
    endfunction

    logic                state_reg, state_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    elem_t               front_reg, front_next;
    elem_t               back_reg, back_next;
    logic                pend_front_reg, pend_front_next;

    logic                out_valid_reg, out_valid_next;
    value_t              popped_reg, popped_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    value_t              out_front_reg, out_front_next;
    value_t              out_back_reg, out_back_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic                empty_reg, empty_next;

    logic                accept;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    elem_t               wr_data;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    elem_t               rd_data;
    elem_t               val_w;
    logic                full;
    logic                empty;

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign val_w    = from_port(value);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        pend_front_next = pend_front_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        popped_next     = popped_reg;
        status_next     = status_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        occ_next        = occ_reg;
        empty_next      = empty_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = val_w;
        rd_en           = 1'b0;
        rd_addr         = '0;

        if (state_reg == S_READ)
        begin
            // new end element has arrived from the store
            if (pend_front_reg)
            begin
                front_next = rd_data;
            end
            else
            begin
                back_next = rd_data;
            end
            out_front_next = pend_front_reg ? to_port(rd_data) : to_port(front_reg);
            out_back_next  = pend_front_reg ? to_port(back_reg) : to_port(rd_data);
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
        end
        else if (accept)
        begin
            popped_next = '0;
            status_next = STATUS_DONE;
            unique case (command)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (empty)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            wr_addr    = '0;
                            front_next = val_w;
                            back_next  = val_w;
                        end
                        else if (command == CMD_PUSH_FRONT)
                        begin
                            head_next  = idx_dec(head_reg);
                            wr_addr    = idx_dec(head_reg);
                            front_next = val_w;
                        end
                        else
                        begin
                            tail_next = idx_inc(tail_reg);
                            wr_addr   = idx_inc(tail_reg);
                            back_next = val_w;
                        end
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        if (command == CMD_POP_FRONT)
                        begin
                            popped_next = to_port(front_reg);
                        end
                        else
                        begin
                            popped_next = to_port(back_reg);
                        end
                        if (count_reg > CW'(1))
                        begin
                            // fetch the element that becomes the new end
                            rd_en           = 1'b1;
                            pend_front_next = (command == CMD_POP_FRONT);
                            state_next      = S_READ;
                            if (command == CMD_POP_FRONT)
                            begin
                                head_next = idx_inc(head_reg);
                                rd_addr   = idx_inc(head_reg);
                            end
                            else
                            begin
                                tail_next = idx_dec(tail_reg);
                                rd_addr   = idx_dec(tail_reg);
                            end
                        end
                    end
                end
                default:
                begin
                    // query and unused codes leave the queue alone
                end
            endcase

            occ_next       = to_occ(count_next);
            empty_next     = (count_next == '0);
            out_front_next = (count_next == '0) ? '0 : to_port(front_next);
            out_back_next  = (count_next == '0) ? '0 : to_port(back_next);
            if (state_next == S_IDLE)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        back_reg       <= back_next;
        pend_front_reg <= pend_front_next;
        popped_reg     <= popped_next;
        status_reg     <= status_next;
        out_front_reg  <= out_front_next;
        out_back_reg   <= out_back_next;
        occ_reg        <= occ_next;
        empty_reg      <= empty_next;
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign front_value  = out_front_reg;
    assign back_value   = out_back_reg;
    assign occupancy    = occ_reg;
    assign is_empty     = empty_reg;

endmodule

// ===== hw/rtl/dq_ram.sv =====
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
